FILE: rtl/color_window_mask_centroid_unit_assert.svh
// assertion macros used by the checker file
`ifndef COLOR_WINDOW_MASK_CENTROID_UNIT_ASSERT_SVH
`define COLOR_WINDOW_MASK_CENTROID_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define CWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cwm assertion failed");

// next-cycle implication, quiet during reset
`define CWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cwm assertion failed");

`endif

FILE: rtl/cwm_pkg.sv
// shared types and constants for the color window mask centroid unit
package cwm_pkg;

  localparam int PIX_W    = 8;
  localparam int TOL_W    = 6;
  localparam int FW_W     = 12;
  localparam int POS_W    = 11;
  localparam int SUM_W    = 33;
  localparam int CNT_W    = 23;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 48;
  localparam int ADDR_W   = 5;
  localparam int APB_W    = 32;
  localparam int QDEPTH   = 4;
  localparam int QAW      = $clog2(QDEPTH);
  localparam int QCW      = QAW + 1;
  localparam int STEP_W   = $clog2(POS_W);
  localparam int DSH_W    = CNT_W + POS_W - 1;

  localparam logic [POS_W-1:0] POS_MAX           = '1;
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET = FW_W'(640);

  typedef enum logic [2:0] {
    REG_BLUE_TARGET,
    REG_GREEN_TARGET,
    REG_RED_TARGET,
    REG_BLUE_TOL,
    REG_GREEN_TOL,
    REG_RED_TOL,
    REG_FRAME_WIDTH
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue_target;
    logic [PIX_W-1:0] green_target;
    logic [PIX_W-1:0] red_target;
    logic [TOL_W-1:0] blue_tol;
    logic [TOL_W-1:0] green_tol;
    logic [TOL_W-1:0] red_tol;
    logic [FW_W-1:0]  frame_width;
  } cwm_cfg_t;

  typedef struct packed {
    logic             mask;
    logic             last;
    logic [SUM_W-1:0] row_sum;
    logic [SUM_W-1:0] col_sum;
    logic [CNT_W-1:0] count;
  } cwm_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] match_total;
    logic [POS_W-1:0] centroid_col;
    logic [POS_W-1:0] centroid_row;
    logic             centroid_valid;
    logic             mask_bit;
  } cwm_result_t;

endpackage

FILE: rtl/cwm_regs.sv
// configuration register file behind the apb-style port
module cwm_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cwm_pkg::ADDR_W-1:0] paddr,
  input  logic [cwm_pkg::APB_W-1:0]  pwdata,
  output logic [cwm_pkg::APB_W-1:0]  prdata,
  output logic                       pready,
  output cwm_pkg::cwm_cfg_t          cfg
);
  import cwm_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg             <= '0;
      cfg.frame_width <= FRAME_WIDTH_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_BLUE_TARGET:  cfg.blue_target  <= pwdata[PIX_W-1:0];
        REG_GREEN_TARGET: cfg.green_target <= pwdata[PIX_W-1:0];
        REG_RED_TARGET:   cfg.red_target   <= pwdata[PIX_W-1:0];
        REG_BLUE_TOL:     cfg.blue_tol     <= pwdata[TOL_W-1:0];
        REG_GREEN_TOL:    cfg.green_tol    <= pwdata[TOL_W-1:0];
        REG_RED_TOL:      cfg.red_tol      <= pwdata[TOL_W-1:0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[FW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BLUE_TARGET:  prdata = APB_W'(cfg.blue_target);
      REG_GREEN_TARGET: prdata = APB_W'(cfg.green_target);
      REG_RED_TARGET:   prdata = APB_W'(cfg.red_target);
      REG_BLUE_TOL:     prdata = APB_W'(cfg.blue_tol);
      REG_GREEN_TOL:    prdata = APB_W'(cfg.green_tol);
      REG_RED_TOL:      prdata = APB_W'(cfg.red_tol);
      REG_FRAME_WIDTH:  prdata = APB_W'(cfg.frame_width);
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: rtl/cwm_front.sv
// front end: color window test, position tracking and frame accumulators
module cwm_front (
  input  logic                      clk,
  input  logic                      rst,
  input  cwm_pkg::cwm_cfg_t         cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cwm_pkg::PIX_W-1:0] blue,
  input  logic [cwm_pkg::PIX_W-1:0] green,
  input  logic [cwm_pkg::PIX_W-1:0] red,
  input  logic                      frame_last,
  input  logic                      q_full,
  output logic                      push,
  output cwm_pkg::cwm_item_t        item
);
  import cwm_pkg::*;

  // strict window: t - d < x < t + d, worked without signs
  function automatic logic in_win(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] t,
                                  input logic [TOL_W-1:0] d);
    logic [PIX_W:0] xe;
    logic [PIX_W:0] te;
    logic [PIX_W:0] de;
    xe = {1'b0, x};
    te = {1'b0, t};
    de = (PIX_W+1)'(d);
    return (xe < te + de) && (xe + de > te);
  endfunction

  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] row_pos;
  logic [SUM_W-1:0] row_sum;
  logic [SUM_W-1:0] col_sum;
  logic [CNT_W-1:0] count;

  logic             match;
  logic             add_en;
  logic             end_of_row;
  logic [SUM_W-1:0] row_sum_next;
  logic [SUM_W-1:0] col_sum_next;
  logic [CNT_W-1:0] count_next;

  assign in_ready = ~q_full;
  assign push     = in_valid & in_ready;

  assign match = in_win(blue, cfg.blue_target, cfg.blue_tol)
               & in_win(green, cfg.green_target, cfg.green_tol)
               & in_win(red, cfg.red_target, cfg.red_tol);

  // accumulation freezes once the top bit of the count is set
  assign add_en = match & ~count[CNT_W-1];

  assign row_sum_next = add_en ? row_sum + SUM_W'(row_pos) : row_sum;
  assign col_sum_next = add_en ? col_sum + SUM_W'(col_pos) : col_sum;
  assign count_next   = count + CNT_W'(add_en);

  assign end_of_row = (col_pos == POS_MAX)
                    || ((cfg.frame_width != '0)
                        && (FW_W'(col_pos) + FW_W'(1) == cfg.frame_width));

  always_comb begin
    item.mask    = match;
    item.last    = frame_last;
    item.row_sum = row_sum_next;
    item.col_sum = col_sum_next;
    item.count   = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      row_sum <= '0;
      col_sum <= '0;
      count   <= '0;
    end else if (push) begin
      if (frame_last) begin
        col_pos <= '0;
        row_pos <= '0;
        row_sum <= '0;
        col_sum <= '0;
        count   <= '0;
      end else begin
        row_sum <= row_sum_next;
        col_sum <= col_sum_next;
        count   <= count_next;
        if (end_of_row) begin
          col_pos <= '0;
          row_pos <= row_pos + POS_W'(1);
        end else begin
          col_pos <= col_pos + POS_W'(1);
        end
      end
    end
  end

endmodule

FILE: rtl/cwm_queue.sv
// short item queue between front and back
module cwm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cwm_pkg::cwm_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output cwm_pkg::cwm_item_t head
);
  import cwm_pkg::*;

  cwm_item_t      slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] fill;

  assign full  = (fill == QCW'(QDEPTH));
  assign valid = (fill != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      fill <= fill + QCW'(push) - QCW'(pop);
    end
  end

endmodule

FILE: rtl/cwm_back.sv
// back end: centroid division and output register
module cwm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  cwm_pkg::cwm_item_t   q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cwm_pkg::cwm_result_t result
);
  import cwm_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  rem_row;
  logic [SUM_W-1:0]  rem_col;
  logic [DSH_W-1:0]  dsh;
  logic [POS_W-1:0]  quo_row;
  logic [POS_W-1:0]  quo_col;
  logic [CNT_W-1:0]  total;
  logic              mask_hold;

  logic out_free;
  logic need_div;
  logic start_div;
  logic load_direct;
  logic load_div;
  logic row_ge;
  logic col_ge;

  assign out_free = ~out_valid | out_ready;
  assign need_div = q_item.last & (q_item.count != '0);
  assign row_ge   = (SUM_W'(dsh) <= rem_row);
  assign col_ge   = (SUM_W'(dsh) <= rem_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    start_div   = 1'b0;
    load_direct = 1'b0;
    load_div    = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          if (need_div) begin
            q_pop      = 1'b1;
            start_div  = 1'b1;
            state_next = BK_DIV;
          end else if (out_free) begin
            q_pop       = 1'b1;
            load_direct = 1'b1;
          end
        end
      end
      BK_DIV: begin
        if (step == '0) begin
          state_next = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          load_div   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // restoring division, one quotient bit per lane per cycle, msb first
  always_ff @(posedge clk) begin
    if (start_div) begin
      rem_row   <= q_item.row_sum;
      rem_col   <= q_item.col_sum;
      dsh       <= {q_item.count, {(POS_W-1){1'b0}}};
      total     <= q_item.count;
      mask_hold <= q_item.mask;
      step      <= STEP_W'(POS_W - 1);
      quo_row   <= '0;
      quo_col   <= '0;
    end else if (state == BK_DIV) begin
      if (row_ge) begin
        rem_row <= rem_row - SUM_W'(dsh);
      end
      if (col_ge) begin
        rem_col <= rem_col - SUM_W'(dsh);
      end
      quo_row <= {quo_row[POS_W-2:0], row_ge};
      quo_col <= {quo_col[POS_W-2:0], col_ge};
      dsh     <= dsh >> 1;
      step    <= step - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_direct || load_div) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      result.mask_bit       <= q_item.mask;
      result.centroid_valid <= q_item.last;
      result.centroid_row   <= '0;
      result.centroid_col   <= '0;
      result.match_total    <= q_item.last ? q_item.count : '0;
    end else if (load_div) begin
      result.mask_bit       <= mask_hold;
      result.centroid_valid <= 1'b1;
      result.centroid_row   <= quo_row;
      result.centroid_col   <= quo_col;
      result.match_total    <= total;
    end
  end

endmodule

FILE: rtl/color_window_mask_centroid_unit.sv
// a pixel result passes through the item queue and then the output register, loaded when the back end is free
// a frame-end beat with matches goes through the shared restoring divider (one quotient bit
// of row and column per cycle), then waits in the hold state until the output register is free
// throughput: one pixel per cycle while the queue has room; each frame end occupies the back end
// for the whole division, absorbed by the 4-entry queue, after which s_tready drops until it drains
// reset (rst, synchronous, active high): position, sums, count and queue clear, regs to defaults
module color_window_mask_centroid_unit (
  input  logic                         clk,
  input  logic                         rst,
  // pixel input
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [cwm_pkg::S_DATA_W-1:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic                         s_tlast,   // frame_last
  // result output
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [cwm_pkg::M_DATA_W-1:0] m_tdata,   // mask_bit[0], centroid_row[11:1],
                                                  // centroid_col[22:12], match_total[45:23]
  output logic                         m_tlast,   // centroid_valid
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cwm_pkg::ADDR_W-1:0]   paddr,
  input  logic [cwm_pkg::APB_W-1:0]    pwdata,
  output logic [cwm_pkg::APB_W-1:0]    prdata,
  output logic                         pready
);
  import cwm_pkg::*;

  cwm_cfg_t    cfg;
  cwm_item_t   push_item;
  cwm_item_t   head_item;
  cwm_result_t result;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;

  // register file; the user must write it only while the stream is idle, the block does not enforce this
  cwm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front end classifies each beat and snapshots the running frame sums into the queue
  cwm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .blue       (s_tdata[PIX_W-1:0]),
    .green      (s_tdata[2*PIX_W-1:PIX_W]),
    .red        (s_tdata[3*PIX_W-1:2*PIX_W]),
    .frame_last (s_tlast),
    .q_full     (q_full),
    .push       (push),
    .item       (push_item)
  );

  // decouples the per-pixel path from the frame-end division
  cwm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (head_item)
  );

  // back end passes mask beats straight through and divides on a frame end with matches
  cwm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  // pack result fields lowest first, zero pad to whole bytes
  assign m_tdata = {{(M_DATA_W-CNT_W-2*POS_W-1){1'b0}}, result.match_total,
                    result.centroid_col, result.centroid_row, result.mask_bit};
  assign m_tlast = result.centroid_valid;

endmodule

FILE: rtl/cwm_checker.sv
// port-level checks on the result stream, bound to the top level
`include "color_window_mask_centroid_unit_assert.svh"

module cwm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [cwm_pkg::M_DATA_W-1:0] m_tdata,
  input logic                         m_tlast
);
  import cwm_pkg::*;

  // a stalled result beat holds
  `CWM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  // beats that are not frame end carry only the mask bit
  `CWM_ASSERT_NOW(a_mid_zero, m_tvalid && !m_tlast, m_tdata[M_DATA_W-1:1] == '0)
  // no matches means a zero centroid
  `CWM_ASSERT_NOW(a_empty_zero, m_tvalid && m_tlast && (m_tdata[45:23] == '0), m_tdata[22:1] == '0)
  // match count never passes the value with only its top bit set
  `CWM_ASSERT_NOW(a_total_cap, m_tvalid && m_tdata[45], m_tdata[44:23] == '0)

endmodule

bind color_window_mask_centroid_unit cwm_checker u_cwm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
